### rtl/bcomp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bcomp_pkg;

    // Field widths
    localparam int RAW_W   = 24;
    localparam int COEF_W  = 16;
    localparam int TEMP_W  = 15;
    localparam int PRES_W  = 17;
    localparam int CFG_IDX_W = 3;

    // Internal widths
    localparam int DT_W    = RAW_W + 1;          // signed temperature difference
    localparam int PROD_W  = DT_W + COEF_W;      // dT times a calibration word
    localparam int OFF_W   = 36;                 // offset term
    localparam int SENS_W  = 35;                 // sensitivity term
    localparam int SLO_W   = 17;                 // low unsigned slice of SENS
    localparam int SHI_W   = SENS_W - SLO_W;     // high signed slice of SENS
    localparam int PPLO_W  = RAW_W + SLO_W;
    localparam int PPHI_W  = RAW_W + 1 + SHI_W;
    localparam int FULL_W  = 60;                 // D1 * SENS
    localparam int Q_W     = FULL_W - 21;        // after the shift by 2^21
    localparam int DIFF_W  = Q_W + 1;
    localparam int PSH_W   = DIFF_W - 15;        // after the shift by 2^15

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SENS        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE  = 3'd5;

    // Output limits
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -15'sd4000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 15'sd8500;
    localparam logic [PRES_W-1:0]        PRES_MAX = 17'd131071;
    localparam logic signed [TEMP_W+3:0] TEMP_BASE = 19'sd2000;

    typedef struct packed {
        logic [COEF_W-1:0] sens;
        logic [COEF_W-1:0] offset;
        logic [COEF_W-1:0] sens_temp;
        logic [COEF_W-1:0] offset_temp;
        logic [COEF_W-1:0] ref_temp;
        logic [COEF_W-1:0] temp_slope;
    } bcomp_cfg_t;

    // Handoff from the coefficient section to the pressure section
    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
        logic [RAW_W-1:0]         d1;
    } bcomp_mid_t;

endpackage

`default_nettype wire

### rtl/bcomp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bcomp_in_if;
    logic                         valid;
    logic                         ready;
    logic [bcomp_pkg::RAW_W-1:0]  raw_pressure;
    logic [bcomp_pkg::RAW_W-1:0]  raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bcomp_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bcomp_pkg::TEMP_W-1:0] temperature_centi;
    logic [bcomp_pkg::PRES_W-1:0]        pressure_pa;

    modport source (output valid, output temperature_centi, output pressure_pa, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_pa, output ready);
endinterface

`default_nettype wire

### rtl/baro_temp_pressure_compensation_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Barometric first-order compensation: each request carries a raw 24-bit pressure and
// temperature conversion and yields one result with temperature in 0.01 degC (saturated
// to -4000..8500) and pressure in pascals (saturated to 0..131071). The datapath is a
// six-stage pipeline: dT, the three dT coefficient products, the temperature/offset/
// sensitivity sums, the D1*SENS product split into two partial products, their
// combination, and the offset subtract with saturation. One request is taken every
// cycle while the result side is not stalled, and a stall on the result side backs up
// through the stage valid bits without loss. Calibration words are written through
// cfg_we/cfg_index/cfg_data (index 0..5, others ignored), reset to zero, and must only
// change while no request is in flight.
module baro_temp_pressure_compensation_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    bcomp_in_if.sink                             sample,
    bcomp_out_if.source                          result,
    input  wire logic                            cfg_we,
    input  wire logic [bcomp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bcomp_pkg::COEF_W-1:0]    cfg_data
);
    import bcomp_pkg::*;

    bcomp_cfg_t cfg_reg;
    bcomp_mid_t mid;
    logic       mid_valid;
    logic       mid_ready;

    // Calibration word writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SENS:        cfg_reg.sens        <= cfg_data;
                REG_OFFSET:      cfg_reg.offset      <= cfg_data;
                REG_SENS_TEMP:   cfg_reg.sens_temp   <= cfg_data;
                REG_OFFSET_TEMP: cfg_reg.offset_temp <= cfg_data;
                REG_REF_TEMP:    cfg_reg.ref_temp    <= cfg_data;
                REG_TEMP_SLOPE:  cfg_reg.temp_slope  <= cfg_data;
                default:         ;
            endcase
        end
    end

    bcomp_coef u_coef (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (sample.valid),
        .in_ready        (sample.ready),
        .raw_pressure    (sample.raw_pressure),
        .raw_temperature (sample.raw_temperature),
        .mid_valid       (mid_valid),
        .mid_ready       (mid_ready),
        .mid             (mid)
    );

    bcomp_pres u_pres (
        .clk               (clk),
        .rst_n             (rst_n),
        .mid_valid         (mid_valid),
        .mid_ready         (mid_ready),
        .mid               (mid),
        .out_valid         (result.valid),
        .out_ready         (result.ready),
        .temperature_centi (result.temperature_centi),
        .pressure_pa       (result.pressure_pa)
    );

`ifndef SYNTHESIS
    // A ready result sink never holds off a new request
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        result.ready |-> sample.ready)
        else $error("request refused while result side is ready");

    // Requests are held off only by a stalled result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (result.valid && !result.ready))
        else $error("request refused without a stalled result");

    // Temperature stays inside its saturation range
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.temperature_centi >= TEMP_MIN
                       && result.temperature_centi <= TEMP_MAX))
        else $error("temperature outside saturation range");
`endif

endmodule

`default_nettype wire

### rtl/bcomp_coef.sv
`timescale 1ns / 1ps
`default_nettype none

module bcomp_coef (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire bcomp_pkg::bcomp_cfg_t       cfg,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [bcomp_pkg::RAW_W-1:0] raw_pressure,
    input  wire logic [bcomp_pkg::RAW_W-1:0] raw_temperature,
    output logic                             mid_valid,
    input  wire logic                        mid_ready,
    output bcomp_pkg::bcomp_mid_t            mid
);
    import bcomp_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    logic signed [DT_W-1:0]   dt_next, dt_reg;
    logic [RAW_W-1:0]         d1_s1_reg, d1_s2_reg;
    logic signed [PROD_W-1:0] pt_next, po_next, ps_next;
    logic signed [PROD_W-1:0] pt_reg, po_reg, ps_reg;
    logic signed [TEMP_W+3:0] temp_raw;
    bcomp_mid_t               mid_next, mid_reg;

    // Advance a stage when it is empty or the one after it moves
    assign adv3     = !v3_reg || mid_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    // Stage 1: temperature difference
    assign dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, cfg.ref_temp, 8'b0});

    // Stage 2: dT times the three temperature coefficients
    assign pt_next = dt_reg * $signed({1'b0, cfg.temp_slope});
    assign po_next = dt_reg * $signed({1'b0, cfg.offset_temp});
    assign ps_next = dt_reg * $signed({1'b0, cfg.sens_temp});

    // Stage 3: temperature, offset and sensitivity
    always_comb
    begin
        temp_raw = TEMP_BASE + (TEMP_W+4)'($signed(pt_reg[PROD_W-1:23]));
        if (temp_raw < (TEMP_W+4)'(TEMP_MIN))
            mid_next.temp = TEMP_MIN;
        else if (temp_raw > (TEMP_W+4)'(TEMP_MAX))
            mid_next.temp = TEMP_MAX;
        else
            mid_next.temp = temp_raw[TEMP_W-1:0];
        mid_next.off  = $signed({3'b0, cfg.offset, 17'b0})
                      + OFF_W'($signed(po_reg[PROD_W-1:6]));
        mid_next.sens = $signed({3'b0, cfg.sens, 16'b0})
                      + SENS_W'($signed(ps_reg[PROD_W-1:7]));
        mid_next.d1   = d1_s2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            dt_reg    <= dt_next;
            d1_s1_reg <= raw_pressure;
        end
        if (adv2 && v1_reg)
        begin
            pt_reg    <= pt_next;
            po_reg    <= po_next;
            ps_reg    <= ps_next;
            d1_s2_reg <= d1_s1_reg;
        end
        if (adv3 && v2_reg)
            mid_reg <= mid_next;
    end

    assign mid_valid = v3_reg;
    assign mid       = mid_reg;

endmodule

`default_nettype wire

### rtl/bcomp_pres.sv
`timescale 1ns / 1ps
`default_nettype none

module bcomp_pres (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          mid_valid,
    output logic                               mid_ready,
    input  wire bcomp_pkg::bcomp_mid_t         mid,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [bcomp_pkg::TEMP_W-1:0] temperature_centi,
    output logic [bcomp_pkg::PRES_W-1:0]       pressure_pa
);
    import bcomp_pkg::*;

    logic v4_reg, v5_reg, v6_reg;
    logic adv4, adv5, adv6;

    logic [PPLO_W-1:0]         pp_lo_next, pp_lo_reg;
    logic signed [PPHI_W-1:0]  pp_hi_next, pp_hi_reg;
    logic signed [OFF_W-1:0]   off_s4_reg, off_s5_reg;
    logic signed [TEMP_W-1:0]  temp_s4_reg, temp_s5_reg, temp_s6_reg;
    logic signed [FULL_W-1:0]  full;
    logic signed [Q_W-1:0]     q_next, q_reg;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [PSH_W-1:0]   p_sh;
    logic [PRES_W-1:0]         pres_next, pres_reg;

    // Sign-extend the high partial product to its place in the full word
    function automatic logic [FULL_W-SLO_W-1:0] pp_hi_next_fix(input logic signed [PPHI_W-1:0] x);
        pp_hi_next_fix = (FULL_W-SLO_W)'(x);
    endfunction

    assign adv6      = !v6_reg || out_ready;
    assign adv5      = !v5_reg || adv6;
    assign adv4      = !v4_reg || adv5;
    assign mid_ready = adv4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (adv4) v4_reg <= mid_valid;
            if (adv5) v5_reg <= v4_reg;
            if (adv6) v6_reg <= v5_reg;
        end
    end

    // Stage 4: D1 times SENS as two partial products
    assign pp_lo_next = PPLO_W'(mid.d1 * mid.sens[SLO_W-1:0]);
    assign pp_hi_next = $signed({1'b0, mid.d1}) * $signed(mid.sens[SENS_W-1:SLO_W]);

    // Stage 5: combine the partial products and drop 21 fraction bits
    assign full   = $signed({pp_hi_next_fix(pp_hi_reg), {SLO_W{1'b0}}})
                  + $signed({{(FULL_W-PPLO_W){1'b0}}, pp_lo_reg});
    assign q_next = full[FULL_W-1:21];

    // Stage 6: subtract the offset, drop 15 bits and saturate
    always_comb
    begin
        diff = DIFF_W'(q_reg) - DIFF_W'(off_s5_reg);
        p_sh = diff[DIFF_W-1:15];
        if (p_sh < 0)
            pres_next = '0;
        else if (p_sh > $signed({{(PSH_W-PRES_W){1'b0}}, PRES_MAX}))
            pres_next = PRES_MAX;
        else
            pres_next = p_sh[PRES_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv4 && mid_valid)
        begin
            pp_lo_reg   <= pp_lo_next;
            pp_hi_reg   <= pp_hi_next;
            off_s4_reg  <= mid.off;
            temp_s4_reg <= mid.temp;
        end
        if (adv5 && v4_reg)
        begin
            q_reg       <= q_next;
            off_s5_reg  <= off_s4_reg;
            temp_s5_reg <= temp_s4_reg;
        end
        if (adv6 && v5_reg)
        begin
            pres_reg    <= pres_next;
            temp_s6_reg <= temp_s5_reg;
        end
    end

    assign out_valid         = v6_reg;
    assign temperature_centi = temp_s6_reg;
    assign pressure_pa       = pres_reg;

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bcomp_pkg::*;

    // Run length and pacing
    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned IDLE_PCT    = 18;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned PHASE_ITEMS = 105;
    localparam int unsigned HOLD_AT     = 300;
    localparam int unsigned HOLD_LEN    = 80;
    localparam int unsigned SETTLE      = 20;

    // Register indexes past the last calibration word; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Output clamp limits widened for the 64-bit predictor
    localparam longint TEMP_LO = TEMP_MIN;
    localparam longint TEMP_HI = TEMP_MAX;
    localparam longint PRES_HI = PRES_MAX;

    typedef enum int {CAL_NEAR_TYPICAL, CAL_ANY, CAL_EDGE} cal_kind_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [PRES_W-1:0]        pres;
    } reading_t;

    typedef struct packed {
        logic [2:0]               set_id;
        logic [RAW_W-1:0]         d1;
        logic [RAW_W-1:0]         d2;
        logic                     literal;
        logic signed [TEMP_W-1:0] exp_temp;
        logic [PRES_W-1:0]        exp_pres;
    } vector_t;

    // Calibration sets for the directed part: sens, offset, sens_temp,
    // offset_temp, ref_temp, temp_slope
    localparam bcomp_cfg_t DIR_CAL [6] = '{
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF},
        '{16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF},
        '{16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}
    };

    // Directed requests; literal rows carry the result, the rest use the predictor
    localparam vector_t DIRECTED [21] = '{
        // all-zero calibration after reset: always 20.00 degC, 0 Pa
        '{3'd0, 24'd0, 24'd0, 1'b1, 15'sd2000, 17'd0},
        '{3'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 15'sd2000, 17'd0},
        '{3'd0, 24'hAAAAAA, 24'h555555, 1'b1, 15'sd2000, 17'd0},
        // steepest temperature slope: clamp high, and zero offset
        '{3'd1, 24'd0, 24'hFFFFFF, 1'b1, TEMP_MAX, 17'd0},
        '{3'd1, 24'hFFFFFF, 24'd0, 1'b1, 15'sd2000, 17'd0},
        // largest reference and offset: clamp low, negative pressure
        '{3'd2, 24'd0, 24'd0, 1'b1, TEMP_MIN, 17'd0},
        '{3'd2, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 15'sd0, 17'd0},
        // largest sensitivity: pressure clamps high
        '{3'd3, 24'hFFFFFF, 24'd0, 1'b1, 15'sd2000, PRES_MAX},
        '{3'd3, 24'd0, 24'hFFFFFF, 1'b1, 15'sd2000, 17'd0},
        // typical calibration, including dT of zero and of minus one
        '{3'd4, 24'd6465444, 24'd8077636, 1'b0, 15'sd0, 17'd0},
        '{3'd4, 24'd0, 24'd0, 1'b0, 15'sd0, 17'd0},
        '{3'd4, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 15'sd0, 17'd0},
        '{3'd4, 24'hFFFFFF, 24'd0, 1'b0, 15'sd0, 17'd0},
        '{3'd4, 24'd0, 24'hFFFFFF, 1'b0, 15'sd0, 17'd0},
        '{3'd4, 24'd8000000, 24'd8077568, 1'b0, 15'sd0, 17'd0},
        '{3'd4, 24'd8000000, 24'd8077567, 1'b0, 15'sd0, 17'd0},
        // every word at its maximum
        '{3'd5, 24'd0, 24'd0, 1'b0, 15'sd0, 17'd0},
        '{3'd5, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 15'sd0, 17'd0},
        '{3'd5, 24'hFFFFFF, 24'd0, 1'b0, 15'sd0, 17'd0},
        '{3'd5, 24'd0, 24'hFFFFFF, 1'b0, 15'sd0, 17'd0},
        '{3'd5, 24'd1193046, 24'd16776960, 1'b0, 15'sd0, 17'd0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0] cfg_data;

    bcomp_in_if  in_if ();
    bcomp_out_if out_if ();

    bcomp_cfg_t  cal;
    reading_t    pending_readings [$];
    reading_t    want;
    int unsigned accepted_cnt;
    int unsigned mismatches;
    int unsigned cycles;
    bit          steady;

    baro_temp_pressure_compensation_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (in_if),
        .result    (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Compensated temperature and pressure for one raw pair under the current calibration
    function automatic reading_t compensate(input logic [RAW_W-1:0] d1,
                                            input logic [RAW_W-1:0] d2);
        longint dt;
        longint t;
        longint off;
        longint sens;
        longint p;
        reading_t r;
        dt   = longint'(d2) - longint'(cal.ref_temp) * 256;
        t    = 2000 + ((dt * longint'(cal.temp_slope)) >>> 23);
        off  = longint'(cal.offset) * 131072 + ((dt * longint'(cal.offset_temp)) >>> 6);
        sens = longint'(cal.sens) * 65536 + ((dt * longint'(cal.sens_temp)) >>> 7);
        p    = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
        if (t < TEMP_LO)
            t = TEMP_LO;
        else if (t > TEMP_HI)
            t = TEMP_HI;
        if (p < 0)
            p = 0;
        else if (p > PRES_HI)
            p = PRES_HI;
        r.temp = t[TEMP_W-1:0];
        r.pres = p[PRES_W-1:0];
        return r;
    endfunction

    // Draw a calibration set of the given flavor
    function automatic bcomp_cfg_t pick_calibration(input cal_kind_t kind);
        logic [6*COEF_W-1:0] flat;
        logic [6*COEF_W-1:0] base;
        int v;
        base = DIR_CAL[4];
        for (int k = 0; k < 6; k++)
        begin
            case (kind)
                CAL_NEAR_TYPICAL:
                begin
                    v = int'(base[k*COEF_W +: COEF_W]) + int'($urandom_range(4000)) - 2000;
                    flat[k*COEF_W +: COEF_W] = v[COEF_W-1:0];
                end
                CAL_EDGE:
                    flat[k*COEF_W +: COEF_W] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                default:
                    flat[k*COEF_W +: COEF_W] = COEF_W'($urandom);
            endcase
        end
        return bcomp_cfg_t'(flat);
    endfunction

    // Write all calibration words plus the two unused indexes; called at a falling edge
    task automatic load_calibration(input bcomp_cfg_t c);
        logic [COEF_W-1:0] words [8];
        words[REG_SENS]        = c.sens;
        words[REG_OFFSET]      = c.offset;
        words[REG_SENS_TEMP]   = c.sens_temp;
        words[REG_OFFSET_TEMP] = c.offset_temp;
        words[REG_REF_TEMP]    = c.ref_temp;
        words[REG_TEMP_SLOPE]  = c.temp_slope;
        words[REG_SPARE_LO]    = COEF_W'($urandom);
        words[REG_SPARE_HI]    = COEF_W'($urandom);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data  <= words[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        cal = c;
    endtask

    // Drop valid and wait until every pending result has come back
    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    // Offer one request, with random idle cycles ahead of it unless steady is set; returns at a falling edge
    task automatic offer_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2,
                                input logic literal, input reading_t fixed);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_if.valid           <= 1'b0;
            in_if.raw_pressure    <= RAW_W'($urandom);
            in_if.raw_temperature <= RAW_W'($urandom);
            @(negedge clk);
        end
        in_if.valid           <= 1'b1;
        in_if.raw_pressure    <= d1;
        in_if.raw_temperature <= d2;
        do
            @(posedge clk);
        while (!in_if.ready);
        pending_readings.push_back(literal ? fixed : compensate(d1, d2));
        accepted_cnt++;
        @(negedge clk);
    endtask

    // Result side: random back-pressure and one long hold-off
    initial
    begin : result_side
        bit held_off;
        held_off = 1'b0;
        out_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held_off && accepted_cnt >= HOLD_AT)
            begin
                held_off = 1'b1;
                out_if.ready <= 1'b0;
                for (int k = 0; k < HOLD_LEN; k++)
                    @(negedge clk);
            end
            else
                out_if.ready <= rst_n && (steady || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compare each delivered result against the oldest pending one
    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (pending_readings.size() == 0)
            begin
                $display("%0t: unexpected result temp %0d pres %0d", $time,
                         out_if.temperature_centi, out_if.pressure_pa);
                mismatches++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (out_if.temperature_centi !== want.temp)
                begin
                    $display("%0t: temperature expected %0d got %0d", $time,
                             want.temp, out_if.temperature_centi);
                    mismatches++;
                end
                if (out_if.pressure_pa !== want.pres)
                begin
                    $display("%0t: pressure expected %0d got %0d", $time,
                             want.pres, out_if.pressure_pa);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        logic [2:0] cur_set;
        logic [RAW_W-1:0] d1;
        logic [RAW_W-1:0] d2;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        in_if.valid           = 1'b0;
        in_if.raw_pressure    = '0;
        in_if.raw_temperature = '0;
        cal                   = '0;
        steady                = 1'b0;
        accepted_cnt          = 0;
        mismatches            = 0;
        cycles                = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table, reloading calibration when the set changes
        cur_set = 3'd0;
        foreach (DIRECTED[r])
        begin
            if (DIRECTED[r].set_id != cur_set)
            begin
                drain();
                cur_set = DIRECTED[r].set_id;
                load_calibration(DIR_CAL[cur_set]);
            end
            offer_sample(DIRECTED[r].d1, DIRECTED[r].d2, DIRECTED[r].literal,
                         '{DIRECTED[r].exp_temp, DIRECTED[r].exp_pres});
        end

        // Random phases, each under a fresh calibration; one runs without idling
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            load_calibration(pick_calibration(cal_kind_t'(ph % 3)));
            steady = (ph == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99) < 70)
                begin
                    d1 = RAW_W'($urandom);
                    d2 = RAW_W'($urandom);
                end
                else
                begin
                    d1 = RAW_W'($urandom_range(9000000, 3000000));
                    d2 = RAW_W'($urandom_range(9500000, 7000000));
                end
                offer_sample(d1, d2, 1'b0, '0);
            end
        end
        steady = 1'b0;

        drain();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && pending_readings.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
